[rtl/sliding_window_minimum_core_assert.svh]
// assertion macros for the sliding window minimum core checker
`ifndef SLIDING_WINDOW_MINIMUM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MINIMUM_CORE_ASSERT_SVH

// same-cycle implication
`define SWM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sliding window minimum check failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sliding window minimum check failed");

`endif

[rtl/swm_pkg.sv]
// shared types and constants of the sliding window minimum core
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    localparam logic REG_WINDOW_SIZE = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic load;
        logic seeded;
    } cell_ctl_t;

endpackage

[rtl/swm_cell.sv]
// one cell of the running-minimum row, ordered by sample age
module swm_cell (
    input  logic               aclk,
    input  swm_pkg::cell_ctl_t ctl,
    input  logic               in_window,
    input  swm_pkg::sample_t   sample,
    input  swm_pkg::sample_t   prev_min,
    input  swm_pkg::sample_t   front_min,
    output swm_pkg::sample_t   run_min
);

    swm_pkg::sample_t run_min_reg;
    swm_pkg::sample_t run_min_next;

    always_comb begin
        run_min_next = run_min_reg;
        if (ctl.load) begin
            if (!in_window) begin
                run_min_next = front_min;
            end else if (ctl.seeded && (prev_min < sample)) begin
                run_min_next = prev_min;
            end else begin
                run_min_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        run_min_reg <= run_min_next;
    end

    assign run_min = run_min_reg;

endmodule

[rtl/sliding_window_minimum_core.sv]
// top level of the streaming sliding window minimum core
//
// samples arrive on the s_ stream channel, one signed 32-bit value per transfer;
// window minima leave on the m_ stream channel, one per sample once the window
// has filled. the user must write window_size through the apb port at address 0
// only while the core is idle; the core does not enforce this. 0 acts as 1 and
// values above WINDOW_MAX act as WINDOW_MAX. a row of WINDOW_MAX cells holds,
// for each age, the minimum over the live entries up to that age; each accepted
// sample shifts the row by one cell. throughput is one sample per cycle while
// the skid register is empty, set by the cell update: tap select, one 32-bit
// compare and the broadcast of the front value back into the row. results are
// registered. the first window_size - 1 samples after reset give no result.
// reset clears the window to 1, the fill count and the output buffer; no
// clearing pass is needed, the cell contents are ignored until seeded.
// when the receiver stalls, a second result is caught in a skid register;
// s_tready drops only while both output registers are full.
module sliding_window_minimum_core #(
    parameter int WINDOW_MAX = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // sample[31:0]
    // window_min
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // window_min[31:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int WW = (CW > swm_pkg::CFG_W) ? CW : swm_pkg::CFG_W;
    localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [swm_pkg::CFG_W-1:0] window_reg;
    logic [CW-1:0]             filled_reg;
    logic [CW-1:0]             filled_next;
    logic                      seeded_reg;
    logic                      out_valid_reg;
    swm_pkg::sample_t          out_data_reg;
    logic                      skid_valid_reg;
    swm_pkg::sample_t          skid_data_reg;

    logic                      cfg_write;
    logic                      s_fire;
    logic                      m_fire;
    logic                      have_result;
    logic [WW-1:0]             win_ext;
    logic [WW-1:0]             win_eff;
    logic                      win_ge2;
    logic [IW-1:0]             tap_sel;
    swm_pkg::sample_t          sample;
    swm_pkg::sample_t          tap_min;
    swm_pkg::sample_t          front_min;
    swm_pkg::cell_ctl_t        cell_ctl;
    swm_pkg::sample_t          run_min [WINDOW_MAX];

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == swm_pkg::REG_WINDOW_SIZE)
                     ? {{(32 - swm_pkg::CFG_W){1'b0}}, window_reg} : '0;

    // effective window
    always_comb begin
        win_ext = WW'(window_reg);
        if (win_ext == '0) begin
            win_eff = WW'(1);
        end else if (win_ext > WW'(WINDOW_MAX)) begin
            win_eff = WW'(WINDOW_MAX);
        end else begin
            win_eff = win_ext;
        end
    end

    assign win_ge2 = (win_eff >= WW'(2));
    assign tap_sel = win_ge2 ? IW'(win_eff - WW'(2)) : '0;

    // handshake
    assign sample   = swm_pkg::sample_t'(s_tdata);
    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_fire   = out_valid_reg && m_tready;

    // front of the deque after this sample
    assign tap_min   = run_min[tap_sel];
    assign front_min = (seeded_reg && win_ge2 && (tap_min < sample)) ? tap_min : sample;

    assign filled_next = (filled_reg == CW'(WINDOW_MAX)) ? filled_reg : filled_reg + CW'(1);
    assign have_result = (WW'(filled_next) >= win_eff);

    assign cell_ctl.load   = s_fire;
    assign cell_ctl.seeded = seeded_reg;

    // row of cells, cell 0 takes the newest sample
    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        swm_pkg::sample_t prev_min;
        if (k == 0) begin : g_head
            assign prev_min = sample;
        end else begin : g_body
            assign prev_min = run_min[k-1];
        end

        swm_cell u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl),
            .in_window (WW'(k) < win_eff),
            .sample    (sample),
            .prev_min  (prev_min),
            .front_min (front_min),
            .run_min   (run_min[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg     <= swm_pkg::CFG_W'(1);
            filled_reg     <= '0;
            seeded_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == swm_pkg::REG_WINDOW_SIZE)) begin
                window_reg <= pwdata[swm_pkg::CFG_W-1:0];
            end
            if (s_fire) begin
                filled_reg <= filled_next;
                seeded_reg <= 1'b1;
            end
            // output register with skid
            if (m_fire) begin
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= s_fire && have_result;
                    out_data_reg  <= front_min;
                end
            end else if (s_fire && have_result) begin
                if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= front_min;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg  <= front_min;
                end
            end
        end
    end

endmodule

[rtl/swm_checker.sv]
// port-level checks on the sliding window minimum core and their binding
`include "sliding_window_minimum_core_assert.svh"

module swm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // stalled result holds
    `SWM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // input blocks only while a result waits
    `SWM_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // a full buffer under stall keeps the input blocked
    `SWM_ASSERT_NEXT(a_blocked_stays, aclk, aresetn, m_tvalid && !m_tready && !s_tready, !s_tready)

    // reset empties the output side
    `SWM_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid && s_tready)

endmodule

bind sliding_window_minimum_core swm_checker u_swm_checker (.*);

[verif/sliding_window_minimum_core_tb.sv]
// self-checking testbench for the sliding window minimum core
`timescale 1ns / 1ps

module sliding_window_minimum_core_tb;

    localparam int WINDOW_MAX       = 64;
    localparam int REG_OUT_OF_RANGE = 1;
    localparam int SETTLE_CYCLES    = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 30;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // sample[31:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // window_min[31:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    swm_pkg::sample_t          deque_value[$];
    logic [31:0]               deque_index[$];
    logic [31:0]               next_index    = '0;
    int                        samples_seen  = 0;
    logic [swm_pkg::CFG_W-1:0] window_reg    = 7'd1;

    swm_pkg::sample_t          expected_minima[$];
    swm_pkg::sample_t          oldest_minimum;

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int mismatch_count = 0;
    int samples_sent   = 0;
    int minima_checked = 0;
    int writes_done    = 0;
    int cycle_count    = 0;

    sliding_window_minimum_core #(
        .WINDOW_MAX(WINDOW_MAX)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sliding_window_minimum_core verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s, got %h, expected %h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit window_min_predict(input swm_pkg::sample_t x,
                                              output swm_pkg::sample_t minimum);
        int          span;
        logic [31:0] age;
        span = (window_reg == 0) ? 1
             : ((int'(window_reg) > WINDOW_MAX) ? WINDOW_MAX : int'(window_reg));
        // expired entries leave at the front, possibly several after a shrink
        while (deque_value.size() > 0) begin
            age = next_index - deque_index[0];
            if (age < 32'(span))
                break;
            deque_value.delete(0);
            deque_index.delete(0);
        end
        while (deque_value.size() > 0 && deque_value[$] >= x) begin
            deque_value.delete(deque_value.size() - 1);
            deque_index.delete(deque_index.size() - 1);
        end
        deque_value = {deque_value, x};
        deque_index = {deque_index, next_index};
        next_index++;
        if (samples_seen < WINDOW_MAX)
            samples_seen++;
        minimum = deque_value[0];
        return samples_seen >= span;
    endfunction

    // result side: random stalls and in-order comparison
    always @(posedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= rx_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_minima.size() == 0) begin
                report_mismatch("window_min with nothing expected", m_tdata, '0);
            end else begin
                oldest_minimum = expected_minima[0];
                expected_minima.delete(0);
                if (m_tdata !== oldest_minimum)
                    report_mismatch("window_min", m_tdata, oldest_minimum);
                minima_checked++;
            end
        end
    end

    task automatic send_sample(input logic [31:0] value);
        swm_pkg::sample_t minimum;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (window_min_predict(swm_pkg::sample_t'(value), minimum))
            expected_minima = {expected_minima, minimum};
        samples_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_minima.size() > 0)
            @(posedge aclk);
        // warm-up samples give no result but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input int index, input logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(index * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == int'(swm_pkg::REG_WINDOW_SIZE))
            window_reg = value[swm_pkg::CFG_W-1:0];
        writes_done++;
    endtask

    task automatic test_warmup_extremes();
        write_register(int'(swm_pkg::REG_WINDOW_SIZE), 32'd3);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hffff_ffff);
        send_sample(32'h0000_0001);
        send_sample(32'haaaa_aaaa);
        send_sample(32'h5555_5555);
    endtask

    task automatic test_register_decode();
        write_register(REG_OUT_OF_RANGE, 32'h0000_007f);
        send_sample(32'h0000_0010);
        send_sample(32'h0000_0020);
        send_sample(32'h0000_0030);
    endtask

    task automatic test_window_change();
        // rising ramp fills the deque, then a shrink expires several fronts at once
        write_register(int'(swm_pkg::REG_WINDOW_SIZE), 32'd5);
        send_sample(32'd10);
        send_sample(32'd20);
        send_sample(32'd30);
        send_sample(32'd40);
        send_sample(32'd50);
        write_register(int'(swm_pkg::REG_WINDOW_SIZE), 32'd2);
        send_sample(32'd60);
        send_sample(32'd5);
        write_register(int'(swm_pkg::REG_WINDOW_SIZE), 32'd0);
        send_sample(32'd7);
        send_sample(32'd7);
        write_register(int'(swm_pkg::REG_WINDOW_SIZE), 32'hffff_ff7f);
        send_sample(32'hffff_fff0);
        send_sample(32'h0000_0100);
        send_sample(32'hffff_fff0);
    endtask

    function automatic logic [31:0] sample_value(input int kind, input logic [31:0] base,
                                                 input logic [31:0] step, input int k);
        int offset;
        case (kind) inside
            2, 3: return base + 32'(k) * step;
            4, 5: return base - 32'(k) * step;
            6, 7: begin
                offset = $urandom_range(6);
                return 32'(offset - 3);
            end
            8: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            9: return ($urandom_range(7) == 0) ? $urandom : base + 32'(k) * step;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [swm_pkg::CFG_W-1:0] pick_window();
        case ($urandom_range(7))
            0: return 7'd1;
            1: return 7'd64;
            2: return 7'd0;
            3: return 7'd127;
            4: return 7'd65;
            5: return 7'($urandom_range(2, 8));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic test_random_stream(input int item_count);
        int          sent;
        int          burst;
        int          kind;
        logic [31:0] base;
        logic [31:0] step;
        logic [31:0] word;
        sent = 0;
        while (sent < item_count) begin
            case ($urandom_range(3))
                0: drain_results();
                1: ;
                default: begin
                    word = $urandom;
                    word[swm_pkg::CFG_W-1:0] = pick_window();
                    write_register(int'(swm_pkg::REG_WINDOW_SIZE), word);
                end
            endcase
            burst = $urandom_range(1) ? $urandom_range(8, 30) : $urandom_range(64, 80);
            kind  = $urandom_range(9);
            base  = $urandom;
            step  = $urandom_range(1, 2000);
            for (int k = 0; k < burst && sent < item_count; k++) begin
                send_sample(sample_value(kind, base, step, k));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct  = 13;
        rx_stall_pct = 68;
        test_warmup_extremes();
        test_register_decode();
        test_window_change();
        test_random_stream(142);

        tx_idle_pct  = 68;
        rx_stall_pct = 13;
        test_random_stream(142);

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_stream(142);

        drain_results();
        repeat (8) @(posedge aclk);

        $display("%0d samples sent, %0d window minima checked, %0d register writes",
                 samples_sent, minima_checked, writes_done);
        $display("windows from 0 to 127 incl. clamping, shrinks mid-stream, ties and ramps");
        if (mismatch_count == 0) begin
            $display("sliding_window_minimum_core verification clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("sliding_window_minimum_core verification failed");
        end
        $finish;
    end

endmodule
